@@ hdl/panel_report_on_change_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the panel reporter
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PANEL_REPORT_ON_CHANGE_TOP_DEFINES_SVH
`define PANEL_REPORT_ON_CHANGE_TOP_DEFINES_SVH

// Same-cycle implication.
`define PRC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/prc_pkg.sv @@
// ----------------------------------------------------------------------------
// Panel reporter package
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package prc_pkg;

	localparam int SAMPLES     = 4;
	localparam int SAMPLE_SHIFT = $clog2(SAMPLES);
	localparam int ADC_BITS    = 12;
	localparam int SUM_W       = ADC_BITS + SAMPLE_SHIFT;
	localparam int PCT_W       = 7;
	localparam int PROD_W      = ADC_BITS + PCT_W;
	localparam int TIME_W      = 32;
	localparam int IN_DATA_W   = 80;
	localparam int OUT_DATA_W  = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [ADC_BITS-1:0] ADC_MAX   = {ADC_BITS{1'b1}};
	localparam logic [PCT_W-1:0]    PCT_SCALE = 7'd100;
	localparam logic [PCT_W-1:0]    PCT_MAX   = 7'd100;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = 2'd2;

	localparam logic [15:0]      DEBOUNCE_RST  = 16'd30;
	localparam logic [15:0]      HEARTBEAT_RST = 16'd1000;
	localparam logic [PCT_W-1:0] DEADBAND_RST  = 7'd2;

	typedef logic [SAMPLES-1:0][ADC_BITS-1:0] sample_vec_t;

	typedef struct packed {
		logic [15:0]      debounce;
		logic [15:0]      heartbeat;
		logic [PCT_W-1:0] deadband;
	} cfg_t;

	typedef struct packed {
		logic             lamp_on;
		logic [PCT_W-1:0] brightness;
	} frame_t;

endpackage

@@ hdl/prc_lane.sv @@
// ----------------------------------------------------------------------------
// Sample lane
// Captures one potentiometer sample of a poll into the first stage.
// ----------------------------------------------------------------------------
module prc_lane (
	input  logic                         clk,
	input  logic                         en,
	input  logic [prc_pkg::ADC_BITS-1:0] sample,
	output logic [prc_pkg::ADC_BITS-1:0] sample_s1
);

	always_ff @(posedge clk) begin
		if (en) begin
			sample_s1 <= sample;
		end
	end

endmodule

@@ hdl/prc_merge.sv @@
// ----------------------------------------------------------------------------
// Lane merge and percent scaling
// Sums the lanes, averages, scales by 100 and divides by full scale.
// ----------------------------------------------------------------------------
module prc_merge (
	input  logic                      clk,
	input  logic                      en,
	input  prc_pkg::sample_vec_t      samples_s1,
	output logic [prc_pkg::PCT_W-1:0] pct_s3
);

	logic [prc_pkg::SUM_W-1:0]    sum;
	logic [prc_pkg::ADC_BITS-1:0] avg;
	logic [prc_pkg::PROD_W-1:0]   prod_s2;
	logic [prc_pkg::PCT_W-1:0]    quo;
	logic [prc_pkg::ADC_BITS:0]   rem;

	// The average of full-scale samples never exceeds full scale, so no clamp.
	always_comb begin
		sum = '0;
		for (int i = 0; i < prc_pkg::SAMPLES; i++) begin
			sum = sum + prc_pkg::SUM_W'(samples_s1[i]);
		end
		avg = sum[prc_pkg::SUM_W-1:prc_pkg::SAMPLE_SHIFT];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= prc_pkg::PROD_W'(avg) * prc_pkg::PROD_W'(prc_pkg::PCT_SCALE);
		end
	end

	// Full scale is 2^B - 1, so p = q*(2^B - 1) + (low + q) with q = p >> B.
	// The remainder estimate stays below twice full scale: one correction.
	always_comb begin
		quo = prod_s2[prc_pkg::PROD_W-1:prc_pkg::ADC_BITS];
		rem = {1'b0, prod_s2[prc_pkg::ADC_BITS-1:0]} + (prc_pkg::ADC_BITS+1)'(quo);
		if (rem >= {1'b0, prc_pkg::ADC_MAX}) begin
			quo = quo + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pct_s3 <= quo;
		end
	end

endmodule

@@ hdl/prc_ctrl.sv @@
// ----------------------------------------------------------------------------
// Report control
// Debounces the button, toggles power and decides when a frame goes out.
// ----------------------------------------------------------------------------
module prc_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fire,
	input  prc_pkg::cfg_t              cfg,
	input  logic [prc_pkg::PCT_W-1:0]  pct,
	input  logic                       button,
	input  logic [prc_pkg::TIME_W-1:0] now_ms,
	output logic                       send,
	output prc_pkg::frame_t            frame
);

	logic                       sent_on_q;
	logic [prc_pkg::PCT_W-1:0]  sent_bright_q;
	logic                       ever_sent_q;
	logic [prc_pkg::TIME_W-1:0] last_frame_q;
	logic                       stable_q;
	logic [prc_pkg::TIME_W-1:0] level_time_q;

	logic                       accept;
	logic [prc_pkg::TIME_W-1:0] since_level;
	logic [prc_pkg::TIME_W-1:0] since_frame;
	logic                       on;
	logic [prc_pkg::PCT_W-1:0]  bright;
	logic [prc_pkg::PCT_W:0]    bright_hi;
	logic [prc_pkg::PCT_W:0]    sent_hi;
	logic                       moved;
	logic                       beat;

	always_comb begin
		since_level = now_ms - level_time_q;
		since_frame = now_ms - last_frame_q;
		accept = (button != stable_q) &&
			(since_level > prc_pkg::TIME_W'(cfg.debounce));
		// Only a change to pressed toggles the lamp.
		on = sent_on_q ^ (accept && button);
		bright = on ? pct : '0;
		bright_hi = {1'b0, bright} + {1'b0, cfg.deadband};
		sent_hi = {1'b0, sent_bright_q} + {1'b0, cfg.deadband};
		moved = (bright_hi < {1'b0, sent_bright_q}) || ({1'b0, bright} > sent_hi);
		beat = since_frame >= prc_pkg::TIME_W'(cfg.heartbeat);
		send = !ever_sent_q || (on != sent_on_q) || moved || beat;
		frame.lamp_on = on;
		frame.brightness = bright;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_on_q <= 1'b0;
			sent_bright_q <= '0;
			ever_sent_q <= 1'b0;
			last_frame_q <= '0;
			stable_q <= 1'b1;
			level_time_q <= '0;
		end else if (fire) begin
			if (accept) begin
				stable_q <= button;
				level_time_q <= now_ms;
			end
			if (send) begin
				sent_on_q <= on;
				sent_bright_q <= bright;
				ever_sent_q <= 1'b1;
				last_frame_q <= now_ms;
			end
		end
	end

endmodule

@@ hdl/panel_report_on_change_top.sv @@
// A poll item passes the lane, product and percent registers and then the output buffer on its way to the master side.
// Throughput: one poll item per cycle while the skid entry is empty; the control stage updates its state once per item.
// A two-entry output buffer decouples the sides; input stalls only when both entries are full.
// Reset (arst_n low, asynchronous) clears pipeline valids, the output buffer and the report
// state, and loads the register defaults: debounce 30 ms, heartbeat 1000 ms, deadband 2.
// ----------------------------------------------------------------------------
// Panel report-on-change top level
// Averages four potentiometer samples into a percentage, debounces a toggle
// button and emits an on/brightness frame on the first poll, change, deadband move or heartbeat.
// ----------------------------------------------------------------------------
`include "panel_report_on_change_top_defines.svh"

module panel_report_on_change_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// Poll items.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// s_tdata, lowest bit up: sample_a[11:0], sample_b[23:12], sample_c[35:24],
	// sample_d[47:36], now_ms[79:48].
	input  logic [prc_pkg::IN_DATA_W-1:0]  s_tdata,
	// s_tuser: button_pressed[0].
	input  logic                           s_tuser,
	// Frame items.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// m_tdata, lowest bit up: brightness_pct[6:0], zero pad[7].
	output logic [prc_pkg::OUT_DATA_W-1:0] m_tdata,
	// m_tuser: lamp_on[0].
	output logic                           m_tuser,
	// Register writes.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [prc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [prc_pkg::CFG_DATA_W-1:0] cfg_data
);

	prc_pkg::cfg_t              cfg_q;
	prc_pkg::sample_vec_t       samples_s1;
	logic [prc_pkg::PCT_W-1:0]  pct_s3;

	logic                       v_s1, v_s2, v_s3;
	logic                       button_s1, button_s2, button_s3;
	logic [prc_pkg::TIME_W-1:0] now_s1, now_s2, now_s3;

	logic                       en;
	logic                       fire;
	logic                       push;
	logic                       pop;
	logic                       send;
	prc_pkg::frame_t            frame;

	prc_pkg::frame_t            out_q, skid_q;
	logic                       out_vld_q, skid_vld_q;

	// The whole pipeline moves together; it holds only while the skid
	// entry is occupied, which keeps room for any frame still in flight.
	assign en = !skid_vld_q;
	assign s_tready = en;
	assign fire = v_s3 && en;
	assign push = fire && send;
	assign pop = out_vld_q && m_tready;

	// Register writes are always taken; indexes past the list are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce <= prc_pkg::DEBOUNCE_RST;
			cfg_q.heartbeat <= prc_pkg::HEARTBEAT_RST;
			cfg_q.deadband <= prc_pkg::DEADBAND_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				prc_pkg::CFG_DEBOUNCE: begin
					cfg_q.debounce <= cfg_data;
				end
				prc_pkg::CFG_HEARTBEAT: begin
					cfg_q.heartbeat <= cfg_data;
				end
				prc_pkg::CFG_DEADBAND: begin
					cfg_q.deadband <= cfg_data[prc_pkg::PCT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// One lane per potentiometer sample.
	for (genvar i = 0; i < prc_pkg::SAMPLES; i++) begin : g_lane
		prc_lane u_lane (
			.clk       (clk),
			.en        (en),
			.sample    (s_tdata[i*prc_pkg::ADC_BITS +: prc_pkg::ADC_BITS]),
			.sample_s1 (samples_s1[i])
		);
	end

	// Lane results are summed and scaled to percent over two stages.
	prc_merge u_merge (
		.clk        (clk),
		.en         (en),
		.samples_s1 (samples_s1),
		.pct_s3     (pct_s3)
	);

	// Item valids, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Button level and timestamp travel alongside the samples.
	always_ff @(posedge clk) begin
		if (en) begin
			button_s1 <= s_tuser;
			button_s2 <= button_s1;
			button_s3 <= button_s2;
			now_s1 <= s_tdata[prc_pkg::SAMPLES*prc_pkg::ADC_BITS +: prc_pkg::TIME_W];
			now_s2 <= now_s1;
			now_s3 <= now_s2;
		end
	end

	// Debounce, toggle and frame decision; state changes once per item.
	prc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.cfg    (cfg_q),
		.pct    (pct_s3),
		.button (button_s3),
		.now_ms (now_s3),
		.send   (send),
		.frame  (frame)
	);

	// Two-entry output buffer: the head register drives the port and the
	// skid entry catches a frame that arrives while the head is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_vld_q) begin
					skid_vld_q <= 1'b0;
				end else begin
					out_vld_q <= push;
				end
			end else if (push) begin
				if (out_vld_q) begin
					skid_vld_q <= 1'b1;
				end else begin
					out_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= frame;
			end
		end else if (push) begin
			if (out_vld_q) begin
				skid_q <= frame;
			end else begin
				out_q <= frame;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = {1'b0, out_q.brightness};
	assign m_tuser = out_q.lamp_on;

	`PRC_ASSERT_NOW(a_skid_behind_head, skid_vld_q, out_vld_q, "skid entry used while head is empty")
	`PRC_ASSERT_NEXT(a_push_lands, push, out_vld_q, "emitted frame was lost")
	`PRC_ASSERT_NOW(a_pct_range, out_vld_q, out_q.brightness <= prc_pkg::PCT_MAX, "brightness above 100")
	`PRC_ASSERT_NOW(a_off_dark, out_vld_q && !out_q.lamp_on, out_q.brightness == '0, "lamp off with nonzero brightness")

endmodule
